// ----- sv/drrip_pkg.sv -----
// ----------------------------------------------------------------------------
// drrip_pkg
// Shared constants, types and helper functions of the DRRIP replacement block.
// ----------------------------------------------------------------------------
package drrip_pkg;

  // Geometry and selector configuration.
  localparam int SET_COUNT     = 1024;
  localparam int WAY_COUNT     = 8;
  localparam int SELECTOR_BITS = 10;
  localparam int SELECTOR_MID  = 512;

  localparam int SET_BITS = $clog2(SET_COUNT);
  localparam int WAY_BITS = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int SEL_MAX  = (1 << SELECTOR_BITS) - 1;
  localparam int SEL_RST  = (SELECTOR_MID > SEL_MAX) ? SEL_MAX : SELECTOR_MID;

  // Field widths of the channels.
  localparam int MODE_W    = 3;
  localparam int SET_IDX_W = 10;
  localparam int WAY_W     = 3;
  localparam int RRPV_W    = 2;
  localparam int SEL_W     = 10;
  localparam int POL_W     = 2;

  localparam logic [RRPV_W-1:0] RRPV_TOP = 2'd3;

  // Event codes.
  localparam logic [MODE_W-1:0] MODE_HIT_REQ  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_HIT      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FILL_REQ = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FILL     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_INVAL    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_VICTIM   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_NOP      = 3'd7;

  // Policy codes.
  localparam logic [POL_W-1:0] POL_SRRIP = 2'd0;
  localparam logic [POL_W-1:0] POL_BRRIP = 2'd1;
  localparam logic [POL_W-1:0] POL_DRRIP = 2'd2;

  // Set classification.
  localparam logic [1:0] KIND_STATIC   = 2'd0;
  localparam logic [1:0] KIND_BIMODAL  = 2'd1;
  localparam logic [1:0] KIND_FOLLOWER = 2'd2;

  // Insertion decision carried with a command.
  localparam logic [1:0] BIM_OFF  = 2'd0;
  localparam logic [1:0] BIM_ON   = 2'd1;
  localparam logic [1:0] BIM_DUEL = 2'd2;

  localparam int KIND_HALF = SET_BITS - SET_BITS / 2 - 1;
  localparam int KIND_MW   = SET_BITS - SET_BITS / 2;
  localparam logic [SET_BITS-1:0] KIND_MASK = SET_BITS'((1 << KIND_MW) - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [MODE_W-1:0]   op;
    logic [SET_BITS-1:0] set;
    logic [WAY_BITS-1:0] way;
    logic                release_req;
    logic                prefetch_req;
    logic [1:0]          bim_sel;
    logic                lead_static;
    logic                lead_bimodal;
  } cmd_t;

  typedef struct packed {
    logic [WAY_COUNT-1:0][RRPV_W-1:0] rrpv;
    logic [WAY_COUNT-1:0]             valid;
    logic [WAY_COUNT-1:0]             reuse;
  } row_t;

  localparam row_t ROW_RESET = '{rrpv: {WAY_COUNT{RRPV_TOP}}, valid: '0, reuse: '0};

  function automatic logic [1:0] set_kind(input logic [SET_BITS-1:0] s);
    logic [SET_BITS-1:0] hi;
    hi = s >> KIND_HALF;
    if (hi == (s & KIND_MASK)) begin
      return KIND_STATIC;
    end else if (hi == (~s & KIND_MASK)) begin
      return KIND_BIMODAL;
    end
    return KIND_FOLLOWER;
  endfunction

  function automatic logic [RRPV_W-1:0] request_rrpv(input logic reuse, input logic is_rel,
                                                     input logic is_pf, input logic bim);
    if (!is_pf && (reuse || !is_rel)) begin
      return 2'd0;
    end else if (is_pf && !reuse) begin
      return 2'd1;
    end
    return bim ? 2'd3 : 2'd2;
  endfunction

endpackage

// ----- sv/drrip_in_if.sv -----
// ----------------------------------------------------------------------------
// drrip_in_if
// Event channel into the replacement block.
// ----------------------------------------------------------------------------
interface drrip_in_if;
  import drrip_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [SET_IDX_W-1:0] set_index;
  logic [WAY_W-1:0]     way;
  logic                 release_req;
  logic                 prefetch_req;

  modport source (output valid, output mode, output set_index, output way,
                  output release_req, output prefetch_req, input ready);
  modport sink (input valid, input mode, input set_index, input way,
                input release_req, input prefetch_req, output ready);
endinterface

// ----- sv/drrip_out_if.sv -----
// ----------------------------------------------------------------------------
// drrip_out_if
// Result channel out of the replacement block.
// ----------------------------------------------------------------------------
interface drrip_out_if;
  import drrip_pkg::*;

  logic              valid;
  logic              ready;
  logic [WAY_W-1:0]  victim_way;
  logic              victim_was_invalid;
  logic [RRPV_W-1:0] new_rrpv;
  logic              used_bimodal;
  logic [SEL_W-1:0]  selector_value;

  modport source (output valid, output victim_way, output victim_was_invalid,
                  output new_rrpv, output used_bimodal, output selector_value,
                  input ready);
  modport sink (input valid, input victim_way, input victim_was_invalid,
                input new_rrpv, input used_bimodal, input selector_value,
                output ready);
endinterface

// ----- sv/drrip_front.sv -----
// ----------------------------------------------------------------------------
// drrip_front
// Holds the policy register, accepts events and classifies them into commands.
// ----------------------------------------------------------------------------
module drrip_front (
  input  logic                       clk,
  input  logic                       rst,
  drrip_in_if.sink                   req,
  input  logic                       cfg_we,
  input  logic [drrip_pkg::POL_W-1:0] cfg_wdata,
  input  logic                       q_full,
  input  logic                       clearing,
  output logic                       q_push,
  output drrip_pkg::cmd_t            q_cmd
);
  import drrip_pkg::*;

  logic [POL_W-1:0]    policy;
  logic [SET_BITS-1:0] set;
  logic [1:0]          kind;
  logic                way_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_DRRIP;
    end else if (cfg_we) begin
      policy <= cfg_wdata;
    end
  end

  assign req.ready = !q_full && !clearing;
  assign q_push    = req.valid && req.ready;

  // Sets are taken modulo the set count.
  assign set    = req.set_index[SET_BITS-1:0];
  assign kind   = set_kind(set);
  assign way_ok = (32'(req.way) < WAY_COUNT);

  always_comb begin
    q_cmd              = '0;
    q_cmd.set          = set;
    q_cmd.way          = req.way[WAY_BITS-1:0];
    q_cmd.release_req  = req.release_req;
    q_cmd.prefetch_req = req.prefetch_req;

    // A hit, fill or invalidate on a way beyond the set becomes a no-op.
    case (req.mode)
      MODE_HIT_REQ, MODE_HIT, MODE_FILL_REQ, MODE_FILL, MODE_INVAL: begin
        q_cmd.op = way_ok ? req.mode : MODE_NOP;
      end
      MODE_VICTIM: begin
        q_cmd.op = MODE_VICTIM;
      end
      default: begin
        q_cmd.op = MODE_NOP;
      end
    endcase

    case (policy)
      POL_SRRIP: begin
        q_cmd.bim_sel = BIM_OFF;
      end
      POL_BRRIP: begin
        q_cmd.bim_sel = BIM_ON;
      end
      default: begin
        q_cmd.lead_static  = (kind == KIND_STATIC);
        q_cmd.lead_bimodal = (kind == KIND_BIMODAL);
        if (kind == KIND_STATIC) begin
          q_cmd.bim_sel = BIM_OFF;
        end else if (kind == KIND_BIMODAL) begin
          q_cmd.bim_sel = BIM_ON;
        end else begin
          q_cmd.bim_sel = BIM_DUEL;
        end
      end
    endcase
  end

endmodule

// ----- sv/drrip_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// drrip_cmd_queue
// Short command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module drrip_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  drrip_pkg::cmd_t cmd_in,
  output logic            full,
  input  logic            pop,
  output drrip_pkg::cmd_t cmd_out,
  output logic            empty
);
  import drrip_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign cmd_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/drrip_back.sv -----
// ----------------------------------------------------------------------------
// drrip_back
// Owns the set state memory and the dueling selector. Reads one set row,
// updates it and writes it back, then presents the result in a register.
// ----------------------------------------------------------------------------
module drrip_back (
  input  logic                               clk,
  input  logic                               rst,
  input  drrip_pkg::cmd_t                    q_cmd,
  input  logic                               q_empty,
  output logic                               q_pop,
  output logic                               clearing,
  output logic [drrip_pkg::SELECTOR_BITS-1:0] selector,
  drrip_out_if.source                        rsp
);
  import drrip_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]               state;
  logic [1:0]               state_next;
  logic [SET_BITS-1:0]      clr_idx;
  cmd_t                     cur;
  row_t                     mem [SET_COUNT];
  row_t                     rd_row;
  row_t                     row_next;
  row_t                     wr_row;
  logic [SET_BITS-1:0]      wr_addr;
  logic                     wr_en;
  logic                     exec_fire;
  logic                     out_free;
  logic [SELECTOR_BITS-1:0] selector_next;
  logic                     bim;

  // Victim scan results.
  logic                found;
  logic [WAY_BITS-1:0] inv_way;
  logic [WAY_BITS-1:0] best_way;
  logic [RRPV_W-1:0]   best_val;
  logic [RRPV_W-1:0]   inc;
  logic [RRPV_W:0]     aged;

  // Result register.
  logic                out_valid;
  logic [WAY_W-1:0]    res_way;
  logic                res_inv;
  logic [RRPV_W-1:0]   res_rrpv;
  logic                res_bim;
  logic [WAY_W-1:0]    out_way;
  logic                out_inv;
  logic [RRPV_W-1:0]   out_rrpv;
  logic                out_bim;
  logic [SEL_W-1:0]    out_sel;

  assign clearing  = (state == ST_CLEAR);
  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign out_free  = !out_valid || rsp.ready;
  assign exec_fire = (state == ST_EXEC) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == SET_BITS'(SET_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_pop) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      selector <= SELECTOR_BITS'(SEL_RST);
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (exec_fire) begin
        selector <= selector_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
  end

  // Single-port set memory: the read is issued when a command is popped and
  // the write lands while the back is idle for reads, so no bypass is needed.
  assign wr_en   = clearing || exec_fire;
  assign wr_addr = clearing ? clr_idx : cur.set;
  assign wr_row  = clearing ? ROW_RESET : row_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (q_pop) begin
      rd_row <= mem[q_cmd.set];
    end
  end

  // First invalid way, and first way holding the largest prediction value.
  always_comb begin
    found    = 1'b0;
    inv_way  = '0;
    best_way = '0;
    best_val = rd_row.rrpv[0];
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!found) begin
        if (!rd_row.valid[w]) begin
          found   = 1'b1;
          inv_way = WAY_BITS'(w);
        end else if (rd_row.rrpv[w] > best_val) begin
          best_way = WAY_BITS'(w);
          best_val = rd_row.rrpv[w];
        end
      end
    end
  end

  assign inc = RRPV_TOP - best_val;
  assign bim = (cur.bim_sel == BIM_ON) ||
               ((cur.bim_sel == BIM_DUEL) && (32'(selector) >= SELECTOR_MID));

  always_comb begin
    row_next      = rd_row;
    selector_next = selector;
    res_way       = '0;
    res_inv       = 1'b0;
    res_rrpv      = '0;
    res_bim       = 1'b0;
    aged          = '0;
    case (cur.op)
      MODE_HIT_REQ: begin
        res_rrpv = request_rrpv(rd_row.reuse[cur.way], cur.release_req, cur.prefetch_req,
                                bim);
        res_bim  = bim;
        row_next.rrpv[cur.way]  = res_rrpv;
        row_next.reuse[cur.way] = 1'b1;
      end
      MODE_HIT: begin
        row_next.rrpv[cur.way] = '0;
      end
      MODE_FILL_REQ: begin
        if (cur.lead_static && (32'(selector) < SEL_MAX)) begin
          selector_next = selector + 1'b1;
        end else if (cur.lead_bimodal && (selector != '0)) begin
          selector_next = selector - 1'b1;
        end
        res_rrpv = request_rrpv(1'b0, cur.release_req, cur.prefetch_req, bim);
        res_bim  = bim;
        row_next.rrpv[cur.way]  = res_rrpv;
        row_next.reuse[cur.way] = 1'b0;
        row_next.valid[cur.way] = 1'b1;
      end
      MODE_FILL: begin
        res_rrpv = bim ? 2'd3 : 2'd2;
        res_bim  = bim;
        row_next.rrpv[cur.way]  = res_rrpv;
        row_next.valid[cur.way] = 1'b1;
      end
      MODE_INVAL: begin
        row_next.rrpv[cur.way]  = RRPV_TOP;
        row_next.valid[cur.way] = 1'b0;
        row_next.reuse[cur.way] = 1'b0;
      end
      MODE_VICTIM: begin
        if (found) begin
          res_way = WAY_W'(inv_way);
          res_inv = 1'b1;
        end else begin
          // Every way is valid here, so all of them age.
          res_way = WAY_W'(best_way);
          for (int w = 0; w < WAY_COUNT; w++) begin
            aged = {1'b0, rd_row.rrpv[w]} + {1'b0, inc};
            row_next.rrpv[w] = (aged > {1'b0, RRPV_TOP}) ? RRPV_TOP : aged[RRPV_W-1:0];
          end
        end
      end
      default: begin
        row_next = rd_row;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_way  <= res_way;
      out_inv  <= res_inv;
      out_rrpv <= res_rrpv;
      out_bim  <= res_bim;
      out_sel  <= SEL_W'(selector_next);
    end
  end

  assign rsp.valid              = out_valid;
  assign rsp.victim_way         = out_way;
  assign rsp.victim_was_invalid = out_inv;
  assign rsp.new_rrpv           = out_rrpv;
  assign rsp.used_bimodal       = out_bim;
  assign rsp.selector_value     = out_sel;

endmodule

// ----- sv/drrip_replacement_policy.sv -----
// ----------------------------------------------------------------------------
// drrip_replacement_policy: DRRIP replacement state with set dueling.
// Each transaction passes the command queue, a row read, then a row update
// that writes the row back and loads the result register, held while the
// result channel stalls. The single port reads the next row only after that
// write-back. Reset clears all rows while req.ready stays low; cfg writes apply.
// ----------------------------------------------------------------------------
module drrip_replacement_policy (
  input  logic                        clk,
  input  logic                        rst,
  drrip_in_if.sink                    req,
  drrip_out_if.source                 rsp,
  input  logic                        cfg_we,
  input  logic [drrip_pkg::POL_W-1:0] cfg_wdata
);
  import drrip_pkg::*;

  cmd_t                     push_cmd;
  cmd_t                     pop_cmd;
  logic                     q_push;
  logic                     q_pop;
  logic                     q_full;
  logic                     q_empty;
  logic                     clearing;
  logic [SELECTOR_BITS-1:0] selector;

  drrip_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .clearing  (clearing),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  drrip_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .cmd_in  (push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .cmd_out (pop_cmd),
    .empty   (q_empty)
  );

  drrip_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_cmd    (pop_cmd),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .clearing (clearing),
    .selector (selector),
    .rsp      (rsp)
  );

  // The selector moves by at most one step per transaction.
  a_selector_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (selector != $past(selector))) |->
      ((selector == $past(selector) + 1'b1) || (selector == $past(selector) - 1'b1)))
    else $error("dueling selector jumped by more than one");

  // An invalid victim never carries an insertion value or bimodal flag.
  a_victim_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.victim_was_invalid) |-> ((rsp.new_rrpv == '0) && !rsp.used_bimodal))
    else $error("invalid victim result carries insertion fields");

  // No result can appear while the state memory is being cleared.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!rsp.valid && q_empty))
    else $error("result or queued command during clearing pass");

endmodule

// ----- verif/drrip_sb_pkg.sv -----
// ----------------------------------------------------------------------------
// drrip_sb_pkg
// Transaction types and the scoreboard of the DRRIP replacement testbench. The
// scoreboard keeps its own copy of the per-way replacement state and of the
// dueling selector, predicts the result of every accepted event and checks the
// results of the block in order against those predictions.
// ----------------------------------------------------------------------------
package drrip_sb_pkg;
  import drrip_pkg::*;

  // Codes that the block must treat as no-ops or aliases.
  localparam logic [MODE_W-1:0] MODE_SPARE = 3'd6;
  localparam logic [POL_W-1:0]  POL_SPARE  = 2'd3;

  localparam int LOG_SETS  = $clog2(SET_COUNT);
  localparam int TAG_SHIFT = LOG_SETS - LOG_SETS / 2 - 1;
  localparam int TAG_MASK  = (1 << (LOG_SETS - LOG_SETS / 2)) - 1;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_W-1:0]     way;
    logic                 release_req;
    logic                 prefetch_req;
  } cache_event_t;

  typedef struct packed {
    logic [WAY_W-1:0]  victim_way;
    logic              victim_was_invalid;
    logic [RRPV_W-1:0] new_rrpv;
    logic              used_bimodal;
    logic [SEL_W-1:0]  selector_value;
  } policy_rsp_t;

  class drrip_scoreboard;
    bit [RRPV_W-1:0]  rrpv_tab [SET_COUNT][WAY_COUNT];
    bit               valid_tab [SET_COUNT][WAY_COUNT];
    bit               reuse_tab [SET_COUNT][WAY_COUNT];
    int               selector;
    logic [POL_W-1:0] policy;
    policy_rsp_t      expected_rsp [$];
    int               errors;

    function new();
      for (int s = 0; s < SET_COUNT; s++) begin
        for (int w = 0; w < WAY_COUNT; w++) begin
          rrpv_tab[s][w]  = RRPV_TOP;
          valid_tab[s][w] = 1'b0;
          reuse_tab[s][w] = 1'b0;
        end
      end
      selector = (SELECTOR_MID > SEL_MAX) ? SEL_MAX : SELECTOR_MID;
      policy   = POL_DRRIP;
      errors   = 0;
    endfunction

    function void set_policy(logic [POL_W-1:0] p);
      policy = p;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    // Leader sets are picked out by comparing the upper index bits with the
    // lower bits, or with their complement.
    function logic [1:0] kind_of(int s);
      int upper;
      upper = s >> TAG_SHIFT;
      if (upper == (s & TAG_MASK)) begin
        return KIND_STATIC;
      end
      if (upper == (~s & TAG_MASK)) begin
        return KIND_BIMODAL;
      end
      return KIND_FOLLOWER;
    endfunction

    function bit takes_bimodal(int s);
      logic [1:0] k;
      if (policy == POL_SRRIP) begin
        return 1'b0;
      end
      if (policy == POL_BRRIP) begin
        return 1'b1;
      end
      k = kind_of(s);
      if (k == KIND_STATIC) begin
        return 1'b0;
      end
      if (k == KIND_BIMODAL) begin
        return 1'b1;
      end
      return selector >= SELECTOR_MID;
    endfunction

    function logic [RRPV_W-1:0] insert_rrpv(bit reuse, bit rel, bit pf, bit bim);
      if (!pf && (reuse || !rel)) begin
        return 2'd0;
      end
      if (pf && !reuse) begin
        return 2'd1;
      end
      return bim ? 2'd3 : 2'd2;
    endfunction

    function policy_rsp_t predict(cache_event_t ev);
      policy_rsp_t r;
      int          s;
      int          w;
      int          best;
      int          step;
      int          aged;
      bit          bim;
      bit          found;
      logic [1:0]  k;
      r = '0;
      s = int'(ev.set_index) % SET_COUNT;
      w = int'(ev.way);
      // A way beyond the set leaves everything untouched.
      if (ev.mode != MODE_VICTIM && w >= WAY_COUNT) begin
        ev.mode = MODE_NOP;
      end
      case (ev.mode)
        MODE_HIT_REQ: begin
          bim = takes_bimodal(s);
          r.new_rrpv = insert_rrpv(reuse_tab[s][w], ev.release_req, ev.prefetch_req, bim);
          rrpv_tab[s][w]  = r.new_rrpv;
          reuse_tab[s][w] = 1'b1;
          r.used_bimodal  = bim;
        end
        MODE_HIT: begin
          rrpv_tab[s][w] = 2'd0;
        end
        MODE_FILL_REQ: begin
          if (policy >= POL_DRRIP) begin
            k = kind_of(s);
            if (k == KIND_STATIC && selector < SEL_MAX) begin
              selector++;
            end else if (k == KIND_BIMODAL && selector > 0) begin
              selector--;
            end
          end
          reuse_tab[s][w] = 1'b0;
          bim = takes_bimodal(s);
          r.new_rrpv = insert_rrpv(1'b0, ev.release_req, ev.prefetch_req, bim);
          rrpv_tab[s][w]  = r.new_rrpv;
          valid_tab[s][w] = 1'b1;
          r.used_bimodal  = bim;
        end
        MODE_FILL: begin
          bim = takes_bimodal(s);
          r.new_rrpv = bim ? 2'd3 : 2'd2;
          rrpv_tab[s][w]  = r.new_rrpv;
          valid_tab[s][w] = 1'b1;
          r.used_bimodal  = bim;
        end
        MODE_INVAL: begin
          valid_tab[s][w] = 1'b0;
          reuse_tab[s][w] = 1'b0;
          rrpv_tab[s][w]  = RRPV_TOP;
        end
        MODE_VICTIM: begin
          found = 1'b0;
          best  = 0;
          for (int i = 0; i < WAY_COUNT; i++) begin
            if (!found) begin
              if (!valid_tab[s][i]) begin
                found        = 1'b1;
                r.victim_way = WAY_W'(i);
              end else if (rrpv_tab[s][i] > rrpv_tab[s][best]) begin
                best = i;
              end
            end
          end
          if (found) begin
            r.victim_was_invalid = 1'b1;
          end else begin
            // Age every way so that the victim reaches the top value.
            r.victim_way = WAY_W'(best);
            step = int'(RRPV_TOP) - int'(rrpv_tab[s][best]);
            for (int i = 0; i < WAY_COUNT; i++) begin
              if (valid_tab[s][i]) begin
                aged = int'(rrpv_tab[s][i]) + step;
                rrpv_tab[s][i] = (aged > int'(RRPV_TOP)) ? RRPV_TOP : RRPV_W'(aged);
              end
            end
          end
        end
        default: begin
        end
      endcase
      r.selector_value = SEL_W'(selector);
      return r;
    endfunction

    function void note_event(cache_event_t ev);
      expected_rsp.push_back(predict(ev));
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(policy_rsp_t got);
      policy_rsp_t want;
      if (expected_rsp.size() == 0) begin
        $error("result transaction with no event outstanding");
        errors++;
        return;
      end
      want = expected_rsp.pop_front();
      compare_field("victim_way", want.victim_way, got.victim_way);
      compare_field("victim_was_invalid", want.victim_was_invalid, got.victim_was_invalid);
      compare_field("new_rrpv", want.new_rrpv, got.new_rrpv);
      compare_field("used_bimodal", want.used_bimodal, got.used_bimodal);
      compare_field("selector_value", want.selector_value, got.selector_value);
    endfunction
  endclass

endpackage

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the DRRIP replacement block. A directed sequence covers the
// insertion rules, aging, invalid victims and unused codes; random phases then
// run under every policy setting, one of them pushing the dueling selector to
// its lower bound, with bursty events and a stalling result channel.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import drrip_pkg::*;
  import drrip_sb_pkg::*;

  localparam int LIMIT     = 200000;
  localparam int LONG_HOLD = 300;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we;
  logic [POL_W-1:0] cfg_wdata;
  bit               long_hold_req = 1'b0;
  int               cycles = 0;

  drrip_scoreboard  sb;
  int               static_sets [$];
  int               bimodal_sets [$];
  int               follower_sets [$];
  int               set_pool [8];

  drrip_in_if  req_ch ();
  drrip_out_if rsp_ch ();

  drrip_replacement_policy u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin : rsp_monitor
    policy_rsp_t got;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got.victim_way         = rsp_ch.victim_way;
      got.victim_was_invalid = rsp_ch.victim_was_invalid;
      got.new_rrpv           = rsp_ch.new_rrpv;
      got.used_bimodal       = rsp_ch.used_bimodal;
      got.selector_value     = rsp_ch.selector_value;
      sb.check_result(got);
    end
  end

  // The result side switches between stall styles, and on request refuses
  // every transaction for a long stretch so that the block backs up.
  initial begin : rsp_stall
    int style;
    int style_left;
    int hold_left;
    rsp_ch.ready = 1'b0;
    style        = 0;
    style_left   = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 3);
          style_left = $urandom_range(16, 96);
        end
        style_left--;
        case (style)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 99) >= 25);
          2: rsp_ch.ready <= ($urandom_range(0, 99) >= 70);
          default: rsp_ch.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  function automatic cache_event_t mk(logic [MODE_W-1:0] mode, int set, int way,
                                      bit rel, bit pf);
    cache_event_t ev;
    ev.mode         = mode;
    ev.set_index    = SET_IDX_W'(set);
    ev.way          = WAY_W'(way);
    ev.release_req  = rel;
    ev.prefetch_req = pf;
    return ev;
  endfunction

  // Slots 0-1 hold static leaders, 2-3 bimodal leaders, 4-6 followers and
  // slot 7 any set, so that the sets fill up and victim queries must age.
  function automatic void new_pool();
    set_pool[0] = static_sets[$urandom_range(0, static_sets.size() - 1)];
    set_pool[1] = static_sets[$urandom_range(0, static_sets.size() - 1)];
    set_pool[2] = bimodal_sets[$urandom_range(0, bimodal_sets.size() - 1)];
    set_pool[3] = bimodal_sets[$urandom_range(0, bimodal_sets.size() - 1)];
    set_pool[4] = follower_sets[$urandom_range(0, follower_sets.size() - 1)];
    set_pool[5] = follower_sets[$urandom_range(0, follower_sets.size() - 1)];
    set_pool[6] = follower_sets[$urandom_range(0, follower_sets.size() - 1)];
    set_pool[7] = $urandom_range(0, SET_COUNT - 1);
  endfunction

  function automatic cache_event_t make_event(bit drain);
    cache_event_t ev;
    int           pick;
    ev.way          = WAY_W'($urandom_range(0, WAY_COUNT - 1));
    ev.release_req  = 1'($urandom_range(0, 1));
    ev.prefetch_req = 1'($urandom_range(0, 1));
    if (drain && $urandom_range(0, 99) < 96) begin
      // Misses in bimodal leader sets walk the selector down.
      ev.mode      = MODE_FILL_REQ;
      ev.set_index = SET_IDX_W'(set_pool[2 + $urandom_range(0, 1)]);
      return ev;
    end
    pick = $urandom_range(0, 99);
    if (pick < 18)      ev.mode = MODE_HIT_REQ;
    else if (pick < 28) ev.mode = MODE_HIT;
    else if (pick < 50) ev.mode = MODE_FILL_REQ;
    else if (pick < 64) ev.mode = MODE_FILL;
    else if (pick < 70) ev.mode = MODE_INVAL;
    else if (pick < 94) ev.mode = MODE_VICTIM;
    else if (pick < 97) ev.mode = MODE_SPARE;
    else                ev.mode = MODE_NOP;
    if ($urandom_range(0, 9) == 0) begin
      ev.set_index = SET_IDX_W'($urandom_range(0, (1 << SET_IDX_W) - 1));
    end else begin
      ev.set_index = SET_IDX_W'(set_pool[$urandom_range(0, 7)]);
    end
    return ev;
  endfunction

  task automatic send_event(input cache_event_t ev);
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.mode         <= ev.mode;
    req_ch.set_index    <= ev.set_index;
    req_ch.way          <= ev.way;
    req_ch.release_req  <= ev.release_req;
    req_ch.prefetch_req <= ev.prefetch_req;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_event(ev);
  endtask

  task automatic idle_for(input int n);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_policy(input logic [POL_W-1:0] p);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_policy(p);
  endtask

  task automatic run_phase(input logic [POL_W-1:0] p, input int count, input bit drain,
                           input bit pressure);
    int burst;
    int gap;
    idle_for(1);
    wait_drained();
    write_policy(p);
    new_pool();
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (pressure && n == count / 3) begin
        long_hold_req = 1'b1;
      end
      if (pressure && n == 2 * count / 3) begin
        idle_for(1);
        wait_drained();
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          idle_for(gap);
        end
      end
      send_event(make_event(drain));
      burst--;
    end
  endtask

  initial begin : stimulus
    int full_set;
    req_ch.valid        = 1'b0;
    req_ch.mode         = MODE_NOP;
    req_ch.set_index    = '0;
    req_ch.way          = '0;
    req_ch.release_req  = 1'b0;
    req_ch.prefetch_req = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = POL_DRRIP;
    sb = new();
    for (int s = 0; s < SET_COUNT; s++) begin
      case (sb.kind_of(s))
        KIND_STATIC:  static_sets.push_back(s);
        KIND_BIMODAL: bimodal_sets.push_back(s);
        default:      follower_sets.push_back(s);
      endcase
    end
    full_set = SET_COUNT - 1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, under the reset policy (dynamic).
    send_event(mk(MODE_VICTIM, full_set, 0, 1'b0, 1'b0));
    for (int w = 0; w < WAY_COUNT; w++) begin
      send_event(mk(MODE_FILL_REQ, full_set, w, 1'(w & 1), 1'((w >> 1) & 1)));
    end
    send_event(mk(MODE_VICTIM, full_set, 0, 1'b0, 1'b0));
    send_event(mk(MODE_HIT_REQ, full_set, 0, 1'b1, 1'b0));
    send_event(mk(MODE_HIT_REQ, full_set, 0, 1'b1, 1'b1));
    send_event(mk(MODE_HIT_REQ, full_set, 1, 1'b0, 1'b1));
    send_event(mk(MODE_HIT_REQ, full_set, 0, 1'b0, 1'b0));
    send_event(mk(MODE_HIT, full_set, 2, 1'b1, 1'b1));
    send_event(mk(MODE_FILL, full_set, 3, 1'b0, 1'b0));
    send_event(mk(MODE_INVAL, full_set, 4, 1'b0, 1'b0));
    send_event(mk(MODE_VICTIM, full_set, 7, 1'b1, 1'b1));
    send_event(mk(MODE_FILL_REQ, static_sets[0], 7, 1'b1, 1'b0));
    send_event(mk(MODE_FILL_REQ, bimodal_sets[0], 0, 1'b1, 1'b0));
    send_event(mk(MODE_FILL, bimodal_sets[0], 1, 1'b0, 1'b0));
    send_event(mk(MODE_SPARE, full_set, 5, 1'b1, 1'b1));
    send_event(mk(MODE_NOP, full_set, 6, 1'b0, 1'b1));

    run_phase(POL_DRRIP, 200, 1'b0, 1'b1);
    run_phase(POL_SRRIP, 200, 1'b0, 1'b0);
    run_phase(POL_BRRIP, 200, 1'b0, 1'b0);
    run_phase(POL_DRRIP, 600, 1'b1, 1'b0);
    run_phase(POL_SPARE, 200, 1'b0, 1'b0);

    idle_for(1);
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
